### rtl/htlp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the linear-probe hash table.
// No dependencies.
package htlp_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int KEY_BYTES  = 8;
  localparam int BYTE_W     = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int KEY_W      = 64;
  localparam int VAL_W      = 32;
  localparam int ENTRY_W    = 5;

  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] FNV_MULT  = 64'h0000_0100_0000_01B3;
  localparam logic [SLOT_W-1:0] FNV_BASIS_LO = FNV_BASIS[SLOT_W-1:0];
  localparam logic [SLOT_W-1:0] FNV_MULT_LO  = FNV_MULT[SLOT_W-1:0];

  localparam logic [ENTRY_W-1:0] LOAD_LIMIT_RST = 5'd8;

  typedef enum logic [1:0] {
    FUNC_GET  = 2'd0,
    FUNC_SET  = 2'd1,
    FUNC_NEXT = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    STAT_HIT      = 3'd0,
    STAT_INSERTED = 3'd1,
    STAT_MISS     = 3'd2,
    STAT_ZERO     = 3'd3,
    STAT_FULL     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_CMP,
    ST_SCAN,
    ST_FETCH,
    ST_RESP
  } state_e;

endpackage

### rtl/hash_table_linear_probe_top.sv
`timescale 1ns / 1ps
// Linear-probe hash table: FNV-1a home slot, one byte per cycle, then a
// sequential probe over a 16-entry key/value memory. Depends on htlp_pkg.
//
// Get/set: accept, hash each key byte up to and including the first zero byte
// (at most 8), then probe from the home slot: an empty slot ends the probe, an
// occupied slot is read from memory and then compared; then load the output
// register. Next: accept, scan slots from start_slot, read a found slot, then
// load the output register. Unused function code and refused zero value:
// accept, then load the output register.
// One transaction in flight; a new one is taken while a result waits.
// Reset clears all occupied flags, the entry count and sets load_limit to 8.
module hash_table_linear_probe_top
  import htlp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [ENTRY_W-1:0] cfg_load_limit_i,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [VAL_W-1:0]   value_i,
  input  logic [SLOT_W-1:0]  start_slot_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [VAL_W-1:0]   found_value_o,
  output logic [KEY_W-1:0]   found_key_o,
  output logic [SLOT_W-1:0]  slot_index_o,
  output logic [ENTRY_W-1:0] entry_total_o
);

  state_e              state_q, state_d;
  func_e               func_q, func_d;
  logic [KEY_W-1:0]    nk_q, nk_d;
  logic [VAL_W-1:0]    val_q, val_d;
  logic [SLOT_W-1:0]   hash_q, hash_d;
  logic [BYTE_W-1:0]   byte_q, byte_d;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [SLOT_W-1:0]   n_q, n_d;
  logic [SLOT_COUNT-1:0] used_q, used_d;
  logic [ENTRY_W-1:0]  count_q, count_d;
  logic [ENTRY_W-1:0]  limit_q;
  status_e             res_status_q, res_status_d;
  logic [VAL_W-1:0]    res_val_q, res_val_d;
  logic [KEY_W-1:0]    res_key_q, res_key_d;
  logic [SLOT_W-1:0]   res_idx_q, res_idx_d;
  logic                out_valid_q, out_valid_d;
  logic [2:0]          out_status_q;
  logic [VAL_W-1:0]    out_val_q;
  logic [KEY_W-1:0]    out_key_q;
  logic [SLOT_W-1:0]   out_idx_q;
  logic [ENTRY_W-1:0]  out_total_q;
  logic                out_load;

  logic [KEY_W-1:0]    key_mem [SLOT_COUNT];
  logic [VAL_W-1:0]    val_mem [SLOT_COUNT];
  logic [KEY_W-1:0]    rd_key_q;
  logic [VAL_W-1:0]    rd_val_q;
  logic                mem_we, mem_re;

  logic                in_fire, out_free, keep;
  logic [KEY_W-1:0]    norm_key;
  logic [7:0]          cur_byte;
  logic [SLOT_W-1:0]   hx, hstep;
  logic [2*SLOT_W-1:0] hprod;
  logic                cur_used, key_match, last_probe, last_slot, room, zero_set;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign zero_set    = (func_e'(func_i) == FUNC_SET) && (value_i == '0);

  always_comb begin
    keep = 1'b1;
    for (int i = 0; i < 8; i++) begin
      keep = keep && (key_i[8*i +: 8] != 8'h00) && (i < KEY_BYTES);
      norm_key[8*i +: 8] = keep ? key_i[8*i +: 8] : 8'h00;
    end
  end

  assign cur_byte   = nk_q[8*byte_q +: 8];
  assign hx         = hash_q ^ SLOT_W'(cur_byte);
  assign hprod      = (2*SLOT_W)'(hx) * (2*SLOT_W)'(FNV_MULT_LO);
  assign hstep      = hprod[SLOT_W-1:0];
  assign cur_used   = used_q[idx_q];
  assign key_match  = (rd_key_q == nk_q);
  assign last_probe = (n_q == SLOT_W'(SLOT_COUNT - 1));
  assign last_slot  = (idx_q == SLOT_W'(SLOT_COUNT - 1));
  assign room       = (count_q < limit_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (func_e'(func_i))
            FUNC_GET:  state_d = ST_HASH;
            FUNC_SET:  state_d = zero_set ? ST_RESP : ST_HASH;
            FUNC_NEXT: state_d = ST_SCAN;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_HASH: begin
        if (cur_byte == 8'h00 || byte_q == BYTE_W'(KEY_BYTES - 1)) begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: state_d = cur_used ? ST_CMP : ST_RESP;
      ST_CMP: begin
        state_d = (key_match || last_probe) ? ST_RESP : ST_PROBE;
      end
      ST_SCAN: begin
        if (cur_used) begin
          state_d = ST_FETCH;
        end else if (last_slot) begin
          state_d = ST_RESP;
        end
      end
      ST_FETCH: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    func_d       = func_q;
    nk_d         = nk_q;
    val_d        = val_q;
    hash_d       = hash_q;
    byte_d       = byte_q;
    idx_d        = idx_q;
    n_d          = n_q;
    used_d       = used_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_val_d    = res_val_q;
    res_key_d    = res_key_q;
    res_idx_d    = res_idx_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          func_d       = func_e'(func_i);
          nk_d         = norm_key;
          val_d        = value_i;
          hash_d       = FNV_BASIS_LO;
          byte_d       = '0;
          n_d          = '0;
          idx_d        = start_slot_i;
          res_status_d = zero_set ? STAT_ZERO : STAT_MISS;
          res_val_d    = '0;
          res_key_d    = '0;
          res_idx_d    = '0;
        end
      end
      ST_HASH: begin
        if (cur_byte != 8'h00) begin
          hash_d = hstep;
          byte_d = byte_q + BYTE_W'(1);
          idx_d  = hstep;
        end else begin
          idx_d  = hash_q;
        end
      end
      ST_PROBE: begin
        if (!cur_used) begin
          if (func_q == FUNC_SET) begin
            if (room) begin
              mem_we        = 1'b1;
              used_d[idx_q] = 1'b1;
              count_d       = count_q + ENTRY_W'(1);
              res_status_d  = STAT_INSERTED;
              res_val_d     = val_q;
              res_idx_d     = idx_q;
            end else begin
              res_status_d  = STAT_FULL;
            end
          end
        end else begin
          mem_re = 1'b1;
        end
      end
      ST_CMP: begin
        if (key_match) begin
          res_status_d = STAT_HIT;
          res_idx_d    = idx_q;
          if (func_q == FUNC_SET) begin
            mem_we    = 1'b1;
            res_val_d = val_q;
          end else begin
            res_val_d = rd_val_q;
          end
        end else if (last_probe) begin
          if (func_q == FUNC_SET) begin
            res_status_d = STAT_FULL;
          end
        end else begin
          idx_d = idx_q + SLOT_W'(1);
          n_d   = n_q + SLOT_W'(1);
        end
      end
      ST_SCAN: begin
        if (cur_used) begin
          mem_re = 1'b1;
        end else if (!last_slot) begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end
      ST_FETCH: begin
        res_status_d = STAT_HIT;
        res_val_d    = rd_val_q;
        res_key_d    = rd_key_q;
        res_idx_d    = idx_q;
      end
      ST_RESP: out_load = out_free;
      default: ;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      count_q     <= '0;
      limit_q     <= LOAD_LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_load_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    nk_q         <= nk_d;
    val_q        <= val_d;
    hash_q       <= hash_d;
    byte_q       <= byte_d;
    idx_q        <= idx_d;
    n_q          <= n_d;
    res_status_q <= res_status_d;
    res_val_q    <= res_val_d;
    res_key_q    <= res_key_d;
    res_idx_q    <= res_idx_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_val_q    <= res_val_q;
      out_key_q    <= res_key_q;
      out_idx_q    <= res_idx_q;
      out_total_q  <= count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[idx_q] <= nk_q;
      val_mem[idx_q] <= val_q;
    end
    if (mem_re) begin
      rd_key_q <= key_mem[idx_q];
      rd_val_q <= val_mem[idx_q];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_value_o = out_val_q;
  assign found_key_o   = out_key_q;
  assign slot_index_o  = out_idx_q;
  assign entry_total_o = out_total_q;

  a_count_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ENTRY_W'($countones(used_q)) == count_q)
    else $error("entry count out of step with occupied flags");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("sequencer idle right after accepting a transaction");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE && !cur_used && func_q == FUNC_SET && room)
      |=> (count_q == $past(count_q) + ENTRY_W'(1)))
    else $error("insert did not advance entry count");

  a_inserted_slot_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_INSERTED) |-> used_q[slot_index_o])
    else $error("inserted slot not marked occupied");

endmodule

### dv/tb_hash_table_linear_probe_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for hash_table_linear_probe_top: directed and random
// get/set/next transactions checked against an in-bench table predictor.
// Depends on htlp_pkg and the hash_table_linear_probe_top RTL.
module tb_hash_table_linear_probe_top;
  import htlp_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int POOL_SIZE = 32;
  localparam int IDLE_PAD = 48;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    logic [1:0]        func;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] start;
  } table_op_t;

  typedef struct {
    status_e            status;
    logic [VAL_W-1:0]   value;
    logic [KEY_W-1:0]   key;
    logic [SLOT_W-1:0]  slot;
    logic [ENTRY_W-1:0] total;
  } table_resp_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [ENTRY_W-1:0] cfg_load_limit_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         func_i = '0;
  logic [KEY_W-1:0]   key_i = '0;
  logic [VAL_W-1:0]   value_i = '0;
  logic [SLOT_W-1:0]  start_slot_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         status_o;
  logic [VAL_W-1:0]   found_value_o;
  logic [KEY_W-1:0]   found_key_o;
  logic [SLOT_W-1:0]  slot_index_o;
  logic [ENTRY_W-1:0] entry_total_o;

  hash_table_linear_probe_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_load_limit_i (cfg_load_limit_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .key_i            (key_i),
    .value_i          (value_i),
    .start_slot_i     (start_slot_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .found_value_o    (found_value_o),
    .found_key_o      (found_key_o),
    .slot_index_o     (slot_index_o),
    .entry_total_o    (entry_total_o)
  );

  always #6 clk_i = ~clk_i;

  // Predicted table contents
  logic [KEY_W-1:0]   tbl_key [SLOT_COUNT];
  logic [VAL_W-1:0]   tbl_val [SLOT_COUNT];
  bit                 tbl_used [SLOT_COUNT];
  logic [ENTRY_W-1:0] tbl_count = '0;
  logic [ENTRY_W-1:0] tbl_limit = LOAD_LIMIT_RST;

  table_op_t   op_q[$];
  table_resp_t pending_resp_q[$];
  table_op_t   drv_op;
  table_resp_t want;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int  ops_queued = 0;
  int  resp_seen = 0;
  int  op_seq = 0;
  int  in_gap = 0;
  int  out_hold = 0;
  int  err_count = 0;
  int  quiet_cycles = 0;
  bit  in_fire = 1'b0;

  function automatic logic [KEY_W-1:0] clean_key(logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    r = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (k[8*i +: 8] == 8'd0) break;
      r[8*i +: 8] = k[8*i +: 8];
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] fnv_home(logic [KEY_W-1:0] nk);
    logic [63:0] h;
    h = FNV_BASIS;
    for (int i = 0; i < 8; i++) begin
      if (nk[8*i +: 8] == 8'd0) break;
      h = (h ^ {56'd0, nk[8*i +: 8]}) * FNV_MULT;
    end
    return h[SLOT_W-1:0];
  endfunction

  function automatic bit find_slot(input logic [KEY_W-1:0] nk, output logic [SLOT_W-1:0] pos,
                                   output bit open_found);
    logic [SLOT_W-1:0] idx;
    idx = fnv_home(nk);
    pos = '0;
    open_found = 1'b0;
    for (int n = 0; n < SLOT_COUNT; n++) begin
      if (!tbl_used[idx]) begin
        open_found = 1'b1;
        pos = idx;
        return 1'b0;
      end
      if (tbl_key[idx] == nk) begin
        pos = idx;
        return 1'b1;
      end
      idx++;
    end
    return 1'b0;
  endfunction

  function automatic table_resp_t apply_table_op(logic [1:0] fn, logic [KEY_W-1:0] raw_key,
                                                 logic [VAL_W-1:0] val,
                                                 logic [SLOT_W-1:0] start);
    table_resp_t       r;
    logic [KEY_W-1:0]  nk;
    logic [SLOT_W-1:0] pos;
    bit                hit;
    bit                open_found;
    nk = clean_key(raw_key);
    r.status = STAT_MISS;
    r.value = '0;
    r.key = '0;
    r.slot = '0;
    case (fn)
      FUNC_GET: begin
        hit = find_slot(nk, pos, open_found);
        if (hit) begin
          r.status = STAT_HIT;
          r.value = tbl_val[pos];
          r.slot = pos;
        end
      end
      FUNC_SET: begin
        if (val == '0) begin
          r.status = STAT_ZERO;
        end else begin
          hit = find_slot(nk, pos, open_found);
          if (hit) begin
            tbl_val[pos] = val;
            r.status = STAT_HIT;
            r.value = val;
            r.slot = pos;
          end else if (tbl_count >= tbl_limit || !open_found) begin
            r.status = STAT_FULL;
          end else begin
            tbl_used[pos] = 1'b1;
            tbl_key[pos] = nk;
            tbl_val[pos] = val;
            tbl_count++;
            r.status = STAT_INSERTED;
            r.value = val;
            r.slot = pos;
          end
        end
      end
      FUNC_NEXT: begin
        for (int i = start; i < SLOT_COUNT; i++) begin
          if (tbl_used[i]) begin
            r.status = STAT_HIT;
            r.value = tbl_val[i];
            r.key = tbl_key[i];
            r.slot = SLOT_W'(i);
            break;
          end
        end
      end
      default: begin
      end
    endcase
    r.total = tbl_count;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, exp_val);
    err_count++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  function automatic void push_op(logic [1:0] fn, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                                  logic [SLOT_W-1:0] s);
    op_q.push_back('{fn, k, v, s});
    ops_queued++;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    int len;
    k = '0;
    len = $urandom_range(0, 8);
    for (int i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int len;
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    len = 0;
    while (len < 8 && k[8*len +: 8] != 8'd0) len++;
    if (len < 7 && $urandom_range(0, 1) == 1) begin
      for (int i = len + 1; i < 8; i++) k[8*i +: 8] = 8'($urandom);
    end
    return k;
  endfunction

  function automatic void push_random_op();
    int sel;
    logic [1:0] fn;
    logic [VAL_W-1:0] val;
    sel = $urandom_range(0, 99);
    if (sel < 35) fn = FUNC_GET;
    else if (sel < 80) fn = FUNC_SET;
    else if (sel < 95) fn = FUNC_NEXT;
    else fn = FUNC_NONE;
    sel = $urandom_range(0, 19);
    if (sel == 0) val = '0;
    else if (sel == 1) val = '1;
    else val = $urandom;
    push_op(fn, pick_key(), val, SLOT_W'($urandom_range(0, SLOT_COUNT - 1)));
  endfunction

  task automatic wait_idle();
    while (resp_seen < ops_queued) @(negedge clk_i);
    repeat (IDLE_PAD) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [ENTRY_W-1:0] lim);
    @(negedge clk_i);
    cfg_load_limit_i <= lim;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    tbl_limit = lim;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Input driver: hold while stalled, advance after each accepted transaction
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (op_q.size() > 0) begin
        drv_op = op_q.pop_front();
        func_i <= drv_op.func;
        key_i <= drv_op.key;
        value_i <= drv_op.value;
        start_slot_i <= drv_op.start;
        in_valid_i <= 1'b1;
        in_gap = (op_seq % 120 < 30) ? 0 : $urandom_range(0, 15);
        op_seq++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (in_fire)
      pending_resp_q.push_back(apply_table_op(func_i, key_i, value_i, start_slot_i));
  end

  // Result side: stall for a drawn number of cycles after each transaction
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (out_hold > 0) begin
      out_stall_i <= 1'b1;
      out_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_resp_q.size() == 0) begin
        report_mismatch("unexpected result status", status_o, '0);
      end else begin
        want = pending_resp_q.pop_front();
        check_field("status", status_o, want.status);
        check_field("found_value", found_value_o, want.value);
        check_field("found_key", found_key_o, want.key);
        check_field("slot_index", slot_index_o, want.slot);
        check_field("entry_total", entry_total_o, want.total);
      end
      out_hold = (resp_seen % 100 < 25) ? 0 : $urandom_range(0, 15);
      resp_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[hash_table_linear_probe_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand_key();
    key_pool[0] = 64'h0000_0000_0000_7A79;

    push_op(FUNC_GET, key_pool[0], 32'd1, 4'd0);
    push_op(FUNC_NEXT, '0, '0, 4'd0);
    push_op(FUNC_NONE, '1, '1, 4'hF);
    push_op(FUNC_SET, key_pool[0], '0, 4'd0);
    push_op(FUNC_SET, '0, 32'hFFFF_FFFF, 4'd0);
    push_op(FUNC_SET, 64'hFFFF_FF00_0000_6261, 32'h0000_0001, 4'd0);
    push_op(FUNC_GET, 64'h0000_0000_0000_6261, '0, 4'd0);
    push_op(FUNC_SET, 64'h1234_0000_0000_6261, 32'h0000_0002, 4'd0);
    push_op(FUNC_SET, '1, 32'h8000_0000, 4'd0);
    push_op(FUNC_GET, '1, '0, 4'd0);
    push_op(FUNC_SET, 64'hFFFF_FFFF_FFFF_FF00, 32'h0000_0005, 4'd0);
    push_op(FUNC_GET, key_pool[0], '0, 4'd0);
    push_op(FUNC_NEXT, '0, '0, 4'd0);
    push_op(FUNC_NEXT, '0, '0, 4'd7);
    push_op(FUNC_NEXT, '0, '0, 4'hF);

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    write_limit('0);
    push_op(FUNC_SET, key_pool[1], 32'h0000_0033, 4'd0);
    push_op(FUNC_SET, '0, 32'h0000_0044, 4'd0);
    push_op(FUNC_GET, '0, '0, 4'd0);
    push_op(FUNC_NEXT, '0, '0, 4'd3);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      write_limit(ENTRY_W'($urandom_range(1, 15)));
      repeat (90) push_random_op();
      wait_idle();
    end

    write_limit(5'd16);
    repeat (40) push_op(FUNC_SET, {$urandom, $urandom}, $urandom_range(1, 32'hFFFF_FFFF), 4'd0);
    repeat (150) push_random_op();
    wait_idle();

    write_limit(5'd31);
    repeat (130) push_random_op();
    wait_idle();

    if (err_count == 0) begin
      $display("[hash_table_linear_probe_top] OK");
    end else begin
      $display("[hash_table_linear_probe_top] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/htlp_pkg.sv
rtl/hash_table_linear_probe_top.sv
dv/tb_hash_table_linear_probe_top.sv
